// ----- hw/rtl/osa_edit_distance_core_defines.svh -----
// ----------------------------------------------------------------------------
// OSA edit distance core assertion macros
// Assertion helpers used by the edit distance core. In synthesis they expand
// to nothing.
// ----------------------------------------------------------------------------
`ifndef OSA_EDIT_DISTANCE_CORE_DEFINES_SVH
`define OSA_EDIT_DISTANCE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication checked at every rising edge outside reset.
`define OSA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked at every rising edge outside reset.
`define OSA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define OSA_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define OSA_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/osa_pkg.sv -----
// ----------------------------------------------------------------------------
// OSA edit distance package
// Shared constants, request codes and types of the edit distance core.
// ----------------------------------------------------------------------------
package osa_pkg;

   // Default string capacity in characters.
   localparam int OSA_MAX_LEN = 128;

   // Width and ceiling of the reported distance.
   localparam int         OSA_DIST_W   = 8;
   localparam logic [7:0] OSA_DIST_MAX = 8'hFF;

   // Request action codes.
   localparam logic [1:0] OSA_ACT_FIRST   = 2'd0;
   localparam logic [1:0] OSA_ACT_SECOND  = 2'd1;
   localparam logic [1:0] OSA_ACT_COMPARE = 2'd2;

   // Sequencer states.
   typedef enum logic [2:0] {
      OSA_IDLE,
      OSA_ROW,
      OSA_CELL_RD,
      OSA_CALC,
      OSA_FINISH
   } osa_state_type;

   // Control from the sequencer to the row store.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic advance;
   } osa_row_ctrl_type;

endpackage

// ----- hw/rtl/osa_if.sv -----
// ----------------------------------------------------------------------------
// OSA edit distance channels
// Valid/ready channels for requests and distance results.
// ----------------------------------------------------------------------------

// Request channel: one character load or a compare.
interface osa_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] character;

   modport source (output valid, output action, output character, input ready);
   modport sink (input valid, input action, input character, output ready);
endinterface

// Result channel: one distance per compare.
interface osa_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] distance;
   logic       truncated;

   modport source (output valid, output distance, output truncated, input ready);
   modport sink (input valid, input distance, input truncated, output ready);
endinterface

// ----- hw/rtl/osa_row_store.sv -----
// ----------------------------------------------------------------------------
// OSA row store
// Three rotating row memories of the distance table: the row being written,
// the row above it and the row two above it. Column j lives at address j-1.
// ----------------------------------------------------------------------------
module osa_row_store #(
   parameter int MAX_LEN = osa_pkg::OSA_MAX_LEN
) (
   input  logic                          clock,
   input  logic                          reset,
   input  osa_pkg::osa_row_ctrl_type     ctrl,
   input  logic [$clog2(MAX_LEN)-1:0]    rd_addr_prev,
   input  logic [$clog2(MAX_LEN)-1:0]    rd_addr_prev2,
   input  logic [$clog2(MAX_LEN)-1:0]    wr_addr,
   input  logic [$clog2(MAX_LEN+1)-1:0]  wr_data,
   output logic [$clog2(MAX_LEN+1)-1:0]  prev_rdata,
   output logic [$clog2(MAX_LEN+1)-1:0]  prev2_rdata
);

   localparam int AW = $clog2(MAX_LEN);
   localparam int LW = $clog2(MAX_LEN+1);
   localparam int NUM_BANKS = 3;
   localparam logic [1:0] ROLE_0 = 2'd0;
   localparam logic [1:0] ROLE_1 = 2'd1;
   localparam logic [1:0] ROLE_2 = 2'd2;

   logic [1:0]    role_ff;
   logic [1:0]    role_in;
   logic [1:0]    prev_sel;
   logic [LW-1:0] bank_rdata [NUM_BANKS];

   // The current row rotates one bank forward at each new row.
   always_comb begin
      role_in = role_ff;
      if (ctrl.advance) begin
         role_in = (role_ff == ROLE_2) ? ROLE_0 : role_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         role_ff <= ROLE_0;
      end else begin
         role_ff <= role_in;
      end
   end

   // Banks holding the previous row and the row before it.
   always_comb begin
      case (role_ff)
         ROLE_0: begin
            prev_sel    = ROLE_2;
            prev_rdata  = bank_rdata[2];
            prev2_rdata = bank_rdata[1];
         end
         ROLE_1: begin
            prev_sel    = ROLE_0;
            prev_rdata  = bank_rdata[0];
            prev2_rdata = bank_rdata[2];
         end
         default: begin
            prev_sel    = ROLE_1;
            prev_rdata  = bank_rdata[1];
            prev2_rdata = bank_rdata[0];
         end
      endcase
   end

   // One write and one registered read per bank and cycle.
   for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      logic [LW-1:0] mem [MAX_LEN];
      logic [LW-1:0] rdata_ff;
      logic [AW-1:0] rd_addr;
      logic          wr_sel;

      assign rd_addr = (prev_sel == 2'(b)) ? rd_addr_prev : rd_addr_prev2;
      assign wr_sel  = ctrl.wr_en && (role_ff == 2'(b));

      always_ff @(posedge clock) begin
         if (wr_sel) begin
            mem[wr_addr] <= wr_data;
         end
         if (ctrl.rd_en) begin
            rdata_ff <= mem[rd_addr];
         end
      end

      assign bank_rdata[b] = rdata_ff;
   end

endmodule

// ----- hw/rtl/osa_edit_distance_core.sv -----
// ----------------------------------------------------------------------------
// OSA edit distance core
// Loads two byte strings and reports their optimal string alignment
// (restricted Damerau-Levenshtein) distance on a compare request.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one request per handshake: action 0 appends character to
//   the first string, action 1 to the second, action 2 compares. Action 3 is
//   accepted and ignored. Appends beyond MAX_LEN are dropped and flagged.
//   rsp_bus carries one result per compare: distance (saturated at 255) and
//   truncated. A compare clears both strings and the flag.
// Schedule:
//   A compare of lengths la and lb fills the table one cell at a time in a
//   shared min unit: each row starts by fetching the first-string character,
//   and each cell takes a registered memory read, then a compute and write.
//   If either string is empty the table is skipped and the result goes
//   straight to the output register.
//   req_bus.ready is high only while the sequencer is idle.
// Reset clears the lengths, the flag and the sequencer; no memory clearing
// pass is needed. A finished result waits in an output register, so appends
// keep being accepted while rsp_bus is stalled; the next compare's result
// waits until that register is taken.
// ----------------------------------------------------------------------------
`include "osa_edit_distance_core_defines.svh"

module osa_edit_distance_core #(
   parameter int MAX_LEN = osa_pkg::OSA_MAX_LEN
) (
   input logic        clock,
   input logic        reset,
   osa_req_if.sink    req_bus,
   osa_rsp_if.source  rsp_bus
);

   localparam int AW = $clog2(MAX_LEN);
   localparam int LW = $clog2(MAX_LEN+1);
   localparam int DW = osa_pkg::OSA_DIST_W;
   localparam int SW = (LW > DW) ? LW : DW;
   localparam logic [LW-1:0] LEN_MAX = LW'(MAX_LEN);
   localparam logic [LW-1:0] ONE     = LW'(1);
   localparam logic [LW-1:0] TWO     = LW'(2);
   localparam logic [LW-1:0] THREE   = LW'(3);

   osa_pkg::osa_state_type state_ff, state_in;

   logic [LW-1:0] first_len_ff, first_len_in;
   logic [LW-1:0] second_len_ff, second_len_in;
   logic          overflow_ff, overflow_in;
   logic [LW-1:0] la_ff, la_in;
   logic [LW-1:0] lb_ff, lb_in;
   logic          trunc_ff, trunc_in;
   logic [LW-1:0] i_ff, i_in;
   logic [LW-1:0] j_ff, j_in;
   logic [7:0]    ca_prev_ff, ca_prev_in;
   logic [7:0]    cb_prev_ff, cb_prev_in;
   logic [LW-1:0] up_prev_ff, up_prev_in;
   logic [LW-1:0] left_ff, left_in;
   logic [LW-1:0] result_ff, result_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] rsp_dist_ff, rsp_dist_in;
   logic          rsp_trunc_ff, rsp_trunc_in;

   logic [7:0]    first_mem [MAX_LEN];
   logic [7:0]    second_mem [MAX_LEN];
   logic [7:0]    a_rdata_ff;
   logic [7:0]    b_rdata_ff;
   logic          a_wr, b_wr, a_rd_en, b_rd_en;

   logic          req_accept;
   logic          rsp_take;
   logic [SW-1:0] result_wide;
   logic [DW-1:0] result_sat;

   osa_pkg::osa_row_ctrl_type row_ctrl;
   logic [LW-1:0] prev_rdata;
   logic [LW-1:0] prev2_rdata;

   logic [LW-1:0] up_val, diag_val, left_val, trans_val, best;
   logic [LW:0]   cand_up, cand_left, cand_sub, cand_trans, min_a, min_b;
   logic          trans_ok;

   assign req_bus.ready = (state_ff == osa_pkg::OSA_IDLE);
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign rsp_take      = rsp_valid_ff && rsp_bus.ready;

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.distance  = rsp_dist_ff;
   assign rsp_bus.truncated = rsp_trunc_ff;

   // String memories: written on appends, read once per row or cell.
   always_ff @(posedge clock) begin
      if (a_wr) begin
         first_mem[AW'(first_len_ff)] <= req_bus.character;
      end
      if (a_rd_en) begin
         a_rdata_ff <= first_mem[AW'(i_ff - ONE)];
      end
   end

   always_ff @(posedge clock) begin
      if (b_wr) begin
         second_mem[AW'(second_len_ff)] <= req_bus.character;
      end
      if (b_rd_en) begin
         b_rdata_ff <= second_mem[AW'(j_ff - ONE)];
      end
   end

   // Rotating rows of the distance table.
   osa_row_store #(
      .MAX_LEN (MAX_LEN)
   ) u_row_store (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (row_ctrl),
      .rd_addr_prev  (AW'(j_ff - ONE)),
      .rd_addr_prev2 (AW'(j_ff - THREE)),
      .wr_addr       (AW'(j_ff - ONE)),
      .wr_data       (best),
      .prev_rdata    (prev_rdata),
      .prev2_rdata   (prev2_rdata)
   );

   // Cell operands; row zero and column zero are their own indexes.
   always_comb begin
      up_val    = (i_ff == ONE) ? j_ff : prev_rdata;
      diag_val  = (j_ff == ONE) ? i_ff - ONE : up_prev_ff;
      left_val  = (j_ff == ONE) ? i_ff : left_ff;
      if (j_ff == TWO) begin
         trans_val = i_ff - TWO;
      end else if (i_ff == TWO) begin
         trans_val = j_ff - TWO;
      end else begin
         trans_val = prev2_rdata;
      end
      trans_ok = (i_ff > ONE) && (j_ff > ONE) && (a_rdata_ff == cb_prev_ff) &&
                 (ca_prev_ff == b_rdata_ff);
   end

   // Shared min unit: deletion, insertion, substitution and transposition.
   always_comb begin
      cand_up    = {1'b0, up_val} + (LW+1)'(1);
      cand_left  = {1'b0, left_val} + (LW+1)'(1);
      cand_sub   = {1'b0, diag_val} + (LW+1)'(a_rdata_ff != b_rdata_ff);
      cand_trans = {1'b0, trans_val} + (LW+1)'(1);
      min_a      = (cand_up < cand_left) ? cand_up : cand_left;
      min_b      = (cand_sub < min_a) ? cand_sub : min_a;
      if (trans_ok && (cand_trans < min_b)) begin
         best = cand_trans[LW-1:0];
      end else begin
         best = min_b[LW-1:0];
      end
   end

   // Distance saturates at the width of the result field.
   assign result_wide = SW'(result_ff);
   assign result_sat  = (result_wide > SW'(osa_pkg::OSA_DIST_MAX)) ?
                        osa_pkg::OSA_DIST_MAX : result_wide[DW-1:0];

   // Sequencer: next state, loads and the cell schedule.
   always_comb begin
      state_in      = state_ff;
      first_len_in  = first_len_ff;
      second_len_in = second_len_ff;
      overflow_in   = overflow_ff;
      la_in         = la_ff;
      lb_in         = lb_ff;
      trunc_in      = trunc_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      ca_prev_in    = ca_prev_ff;
      cb_prev_in    = cb_prev_ff;
      up_prev_in    = up_prev_ff;
      left_in       = left_ff;
      result_in     = result_ff;
      rsp_valid_in  = rsp_take ? 1'b0 : rsp_valid_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_trunc_in  = rsp_trunc_ff;
      a_wr          = 1'b0;
      b_wr          = 1'b0;
      a_rd_en       = 1'b0;
      b_rd_en       = 1'b0;
      row_ctrl      = '0;

      case (state_ff)
         osa_pkg::OSA_IDLE: begin
            if (req_accept) begin
               case (req_bus.action)
                  osa_pkg::OSA_ACT_FIRST: begin
                     if (first_len_ff < LEN_MAX) begin
                        a_wr         = 1'b1;
                        first_len_in = first_len_ff + ONE;
                     end else begin
                        overflow_in = 1'b1;
                     end
                  end
                  osa_pkg::OSA_ACT_SECOND: begin
                     if (second_len_ff < LEN_MAX) begin
                        b_wr          = 1'b1;
                        second_len_in = second_len_ff + ONE;
                     end else begin
                        overflow_in = 1'b1;
                     end
                  end
                  osa_pkg::OSA_ACT_COMPARE: begin
                     la_in         = first_len_ff;
                     lb_in         = second_len_ff;
                     trunc_in      = overflow_ff;
                     first_len_in  = '0;
                     second_len_in = '0;
                     overflow_in   = 1'b0;
                     i_in          = ONE;
                     if ((first_len_ff == '0) || (second_len_ff == '0)) begin
                        result_in = (first_len_ff == '0) ? second_len_ff : first_len_ff;
                        state_in  = osa_pkg::OSA_FINISH;
                     end else begin
                        state_in = osa_pkg::OSA_ROW;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Fetch this row's first-string character, keep the last one.
         osa_pkg::OSA_ROW: begin
            a_rd_en    = 1'b1;
            ca_prev_in = a_rdata_ff;
            j_in       = ONE;
            state_in   = osa_pkg::OSA_CELL_RD;
         end

         // Read the second-string character and the rows above.
         osa_pkg::OSA_CELL_RD: begin
            b_rd_en        = 1'b1;
            row_ctrl.rd_en = 1'b1;
            state_in       = osa_pkg::OSA_CALC;
         end

         // Compute and store one cell, then step the column or row.
         osa_pkg::OSA_CALC: begin
            row_ctrl.wr_en = 1'b1;
            left_in        = best;
            up_prev_in     = up_val;
            cb_prev_in     = b_rdata_ff;
            if (j_ff == lb_ff) begin
               if (i_ff == la_ff) begin
                  result_in = best;
                  state_in  = osa_pkg::OSA_FINISH;
               end else begin
                  i_in             = i_ff + ONE;
                  row_ctrl.advance = 1'b1;
                  state_in         = osa_pkg::OSA_ROW;
               end
            end else begin
               j_in     = j_ff + ONE;
               state_in = osa_pkg::OSA_CELL_RD;
            end
         end

         // Hand the result to the output register once it is free.
         osa_pkg::OSA_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_dist_in  = result_sat;
               rsp_trunc_in = trunc_ff;
               state_in     = osa_pkg::OSA_IDLE;
            end
         end

         default: begin
            state_in = osa_pkg::OSA_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= osa_pkg::OSA_IDLE;
         first_len_ff  <= '0;
         second_len_ff <= '0;
         overflow_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         first_len_ff  <= first_len_in;
         second_len_ff <= second_len_in;
         overflow_ff   <= overflow_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      la_ff        <= la_in;
      lb_ff        <= lb_in;
      trunc_ff     <= trunc_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      ca_prev_ff   <= ca_prev_in;
      cb_prev_ff   <= cb_prev_in;
      up_prev_ff   <= up_prev_in;
      left_ff      <= left_in;
      result_ff    <= result_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_trunc_ff <= rsp_trunc_in;
   end

   // The column stays inside the second string while a cell is computed.
   `OSA_ASSERT_IMP(a_cell_column, clock, reset, state_ff == osa_pkg::OSA_CALC, (j_ff >= ONE) && (j_ff <= lb_ff), "cell column out of range")
   // The row stays inside the first string.
   `OSA_ASSERT_IMP(a_row_range, clock, reset, state_ff == osa_pkg::OSA_ROW, (i_ff >= ONE) && (i_ff <= la_ff), "row index out of range")
   // A compare with an empty string skips the table.
   `OSA_ASSERT_NXT(a_empty_compare, clock, reset, req_accept && (req_bus.action == osa_pkg::OSA_ACT_COMPARE) && ((first_len_ff == '0) || (second_len_ff == '0)), state_ff == osa_pkg::OSA_FINISH, "empty compare did not finish at once")
   // A result appears only when the sequencer hands one over.
   `OSA_ASSERT_IMP(a_rsp_source, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == osa_pkg::OSA_FINISH, "result without a finished compare")

endmodule
